// ===== hw/rtl/bdq_pkg.sv =====
package bdq_pkg;

  localparam int DEPTH      = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 3;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int FILL_W     = 5;

  typedef logic [ELEM_WIDTH-1:0] elem_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  // one spare bit so that position + 1 or + 2 never wraps
  typedef logic [CNT_W:0]        pos_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // request from the sequencer to the ring store
  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    elem_t wr_data;
    idx_t  rd_addr;
  } store_req_t;

  // ring position of the k-th entry from the front, k <= DEPTH + 1
  function automatic idx_t slot_of(idx_t front, pos_t k);
    logic [CNT_W+1:0] sum;
    sum = (CNT_W+2)'(front) + (CNT_W+2)'(k);
    if (sum >= (CNT_W+2)'(DEPTH)) begin
      sum = sum - (CNT_W+2)'(DEPTH);
    end
    if (sum >= (CNT_W+2)'(DEPTH)) begin
      sum = sum - (CNT_W+2)'(DEPTH);
    end
    return idx_t'(sum);
  endfunction

  function automatic elem_t to_elem(logic [VAL_W-1:0] v);
    logic [ELEM_WIDTH+VAL_W-1:0] ext;
    ext = {{ELEM_WIDTH{1'b0}}, v};
    return ext[ELEM_WIDTH-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] from_elem(elem_t e);
    logic [ELEM_WIDTH+VAL_W-1:0] ext;
    ext = {{VAL_W{1'b0}}, e};
    return ext[VAL_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/bounded_deque_with_remove_core.sv =====
// Bounded double-ended queue of DEPTH entries kept in a single-port-write,
// single-port-read ring store, driven by a small sequencer. Each input
// transaction carries one operation (push front/back, pop front/back, or
// remove the first entry equal to in_value) and yields exactly one result
// transaction with the popped value, a status and the fill level after the
// operation. A push, a refused operation or an unused code goes from the
// accepting state straight to S_DONE; a pop passes through S_POP for its one
// store read. Remove walks the ring one entry per cycle through the store's
// read port in S_SCAN; on a match at position k of n entries, S_SHIFT moves
// the n - k - 1 entries behind it down one position, and S_DONE hands over
// the result. A miss goes from S_SCAN straight to S_DONE.
// in_ready is high only while the sequencer is idle. A finished result sits
// in an output register, so the next transaction can be taken while it
// waits for out_ready; if the register is still occupied when the next
// result is ready, that result waits in the sequencer and the block stays
// busy until out_ready frees the register. Store contents are undefined
// after reset; data read from unoccupied positions is never used.
module bounded_deque_with_remove_core
  import bdq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [VAL_W-1:0]    in_value,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [VAL_W-1:0]    out_popped,
  output logic [STATUS_W-1:0] out_status,
  output logic [FILL_W-1:0]   out_fill
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,     // store read in flight for a pop
    S_SCAN,    // searching for the value, one entry a cycle
    S_SHIFT,   // closing the gap behind the match
    S_DONE     // result ready for the output register
  } state_t;

  state_t             state_r, state_nxt;
  idx_t               front_r, front_nxt;
  cnt_t               occ_r, occ_nxt;
  cnt_t               k_r, k_nxt;        // position of the entry on rd_data in S_SCAN
  elem_t              val_r, val_nxt;
  logic [VAL_W-1:0]   res_popped_r, res_popped_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_popped_r, out_popped_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [FILL_W-1:0]  out_fill_r, out_fill_nxt;

  store_req_t         req;
  elem_t              rd_data;

  pos_t               k_p1, k_p2, occ_ext;
  logic               is_full, is_empty;

  bdq_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign k_p1     = {1'b0, k_r} + pos_t'(1);
  assign k_p2     = {1'b0, k_r} + pos_t'(2);
  assign occ_ext  = {1'b0, occ_r};
  assign is_full  = (occ_r == CNT_W'(DEPTH));
  assign is_empty = (occ_r == '0);

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_popped = out_popped_r;
  assign out_status = out_status_r;
  assign out_fill   = out_fill_r;

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    occ_nxt        = occ_r;
    k_nxt          = k_r;
    val_nxt        = val_r;
    res_popped_nxt = res_popped_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_popped_nxt = out_popped_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;

    req.wr_en   = 1'b0;
    req.wr_addr = front_r;
    req.wr_data = val_r;
    req.rd_addr = front_r;

    // output register drains independently of the sequencer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt        = to_elem(in_value);
          res_popped_nxt = '0;
          res_status_nxt = ST_DONE;
          state_nxt      = S_DONE;
          unique case (in_op)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                front_nxt   = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - idx_t'(1);
                req.wr_en   = 1'b1;
                req.wr_addr = front_nxt;
                req.wr_data = to_elem(in_value);
                occ_nxt     = occ_r + cnt_t'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                req.wr_en   = 1'b1;
                req.wr_addr = slot_of(front_r, occ_ext);
                req.wr_data = to_elem(in_value);
                occ_nxt     = occ_r + cnt_t'(1);
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                req.rd_addr = front_r;
                front_nxt   = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + idx_t'(1);
                occ_nxt     = occ_r - cnt_t'(1);
                state_nxt   = S_POP;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                req.rd_addr = slot_of(front_r, occ_ext - pos_t'(1));
                occ_nxt     = occ_r - cnt_t'(1);
                state_nxt   = S_POP;
              end
            end
            OP_REMOVE: begin
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                req.rd_addr = front_r;
                k_nxt       = '0;
                state_nxt   = S_SCAN;
              end
            end
            default: begin
              // unused codes: no effect, reported as done
            end
          endcase
        end
      end

      S_POP: begin
        res_popped_nxt = from_elem(rd_data);
        state_nxt      = S_DONE;
      end

      S_SCAN: begin
        // fetch the next entry speculatively; on a match it is the first to move
        req.rd_addr = slot_of(front_r, k_p1);
        if (rd_data == val_r) begin
          if (k_p1 < occ_ext) begin
            state_nxt = S_SHIFT;
          end else begin
            // match on the tail entry: just drop it
            occ_nxt   = occ_r - cnt_t'(1);
            state_nxt = S_DONE;
          end
        end else if (k_p1 == occ_ext) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          k_nxt = cnt_t'(k_p1);
        end
      end

      S_SHIFT: begin
        // rd_data holds entry k+1; move it down to position k
        req.wr_en   = 1'b1;
        req.wr_addr = slot_of(front_r, {1'b0, k_r});
        req.wr_data = rd_data;
        req.rd_addr = slot_of(front_r, k_p2);
        k_nxt       = cnt_t'(k_p1);
        if (k_p2 == occ_ext) begin
          occ_nxt   = occ_r - cnt_t'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_popped_nxt = res_popped_r;
          out_status_nxt = res_status_r;
          out_fill_nxt   = FILL_W'(occ_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r          <= k_nxt;
    val_r        <= val_nxt;
    res_popped_r <= res_popped_nxt;
    res_status_r <= res_status_nxt;
    out_popped_r <= out_popped_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

`ifndef SYNTHESIS
  a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_push_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !is_full &&
     (in_op == OP_PUSH_FRONT || in_op == OP_PUSH_BACK))
    |=> (occ_r == $past(occ_r) + cnt_t'(1)))
    else $error("accepted push did not add one entry");

  a_front_held : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_SHIFT) |=> $stable(front_r))
    else $error("front moved during remove");

  a_scan_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_SHIFT) |-> (k_r < occ_r))
    else $error("remove position beyond occupancy");
`endif

endmodule

// ===== hw/rtl/bdq_store.sv =====
module bdq_store
  import bdq_pkg::*;
(
  input  logic       clk,
  input  store_req_t req,
  output elem_t      rd_data
);

  elem_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read, data valid the cycle after the address
  always_ff @(posedge clk) begin
    rd_data <= mem[req.rd_addr];
  end

endmodule
